// ===== rtl/htd_pkg.sv =====
package htd_pkg;

  // Default node table depth.
  localparam int unsigned MAX_NODES_DEF = 512;

  // Child index width inside a node entry, and the first parent index that means "no parent".
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned NO_PARENT = 512;

  localparam int unsigned SYMBOLS_W = 64;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_TREE  = 2'd1;
  localparam logic [1:0] STATUS_DONE      = 2'd2;
  localparam logic [1:0] STATUS_LEAF_ROOT = 2'd3;

  // Request types.
  localparam logic REQ_NODE = 1'b0;
  localparam logic REQ_CODE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  node_symbol;
    logic [15:0] node_parent;
    logic [7:0]  code_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       last;
    logic [1:0] status;
  } out_item_t;

  // One node table entry, 28 bits.
  typedef struct packed {
    logic             has_left;
    logic             has_right;
    logic [7:0]       sym;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_entry_t;

  function automatic out_item_t mk_result(logic [7:0] sym, logic valid, logic last,
                                          logic [1:0] status);
    out_item_t r;
    r.symbol       = sym;
    r.symbol_valid = valid;
    r.last         = last;
    r.status       = status;
    return r;
  endfunction

endpackage

// ===== rtl/huffman_tree_decoder.sv =====
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_valid_i/ready_o  cfg_data_i: symbol_total, 64 bits
// in        in         in_valid_i/stall_o   in_data_i: node record or code byte
// out       out        out_valid_o/stall_i  out_data_o: one result per transfer
//
// A node record passes REC, RMW if it has a parent (read-modify-write), then DRAIN.
// A code byte goes through a root read, a current node read, then one bit per cycle
// through the single node table read port while the output slot does not stall the
// walk, then one or two results; the last symbol or a missing right child stops it.
// Early status answers go from BYTE or ROOT to DRAIN; output stalls hold them back.
// Reset clears the control state only; node table entries are defined once written.
module huffman_tree_decoder #(
  parameter int unsigned MAX_NODES = htd_pkg::MAX_NODES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  htd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output htd_pkg::out_item_t out_data_o
);
  import htd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_NODES);

  logic [63:0] symbol_total_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  node_entry_t   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  node_entry_t   mem_rdata;
  logic          emit;
  out_item_t     emit_item;
  logic          slot_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_total_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      symbol_total_q <= cfg_data_i;
    end
  end

  htd_node_mem #(
    .DEPTH (MAX_NODES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  htd_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .symbol_total_i (symbol_total_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .emit_o         (emit),
    .emit_item_o    (emit_item),
    .slot_free_i    (slot_free)
  );

  htd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .emit_item_i (emit_item),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/htd_node_mem.sv =====
module htd_node_mem #(
  parameter int unsigned DEPTH = htd_pkg::MAX_NODES_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  htd_pkg::node_entry_t wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output htd_pkg::node_entry_t rdata_o
);
  import htd_pkg::*;

  node_entry_t mem [DEPTH];
  node_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // The read data holds until the next read, so a paused walk keeps its entry.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/htd_out_stage.sv =====
module htd_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               emit_i,
  input  htd_pkg::out_item_t emit_item_i,
  output logic               slot_free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output htd_pkg::out_item_t out_data_o
);
  import htd_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;

  // The register can take a new result when it is empty or is being emptied this cycle.
  assign slot_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (emit_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i) begin
      data_q <= emit_item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/htd_ctrl.sv =====
module htd_ctrl #(
  parameter int unsigned MAX_NODES = htd_pkg::MAX_NODES_DEF,
  localparam int unsigned AW = $clog2(MAX_NODES)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [63:0]          symbol_total_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  htd_pkg::in_item_t    in_data_i,
  output logic                 mem_we_o,
  output logic [AW-1:0]        mem_waddr_o,
  output htd_pkg::node_entry_t mem_wdata_o,
  output logic                 mem_re_o,
  output logic [AW-1:0]        mem_raddr_o,
  input  htd_pkg::node_entry_t mem_rdata_i,
  output logic                 emit_o,
  output htd_pkg::out_item_t   emit_item_o,
  input  logic                 slot_free_i
);
  import htd_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_REC   = 3'd1;
  localparam logic [2:0] ST_RMW   = 3'd2;
  localparam logic [2:0] ST_BYTE  = 3'd3;
  localparam logic [2:0] ST_ROOT  = 3'd4;
  localparam logic [2:0] ST_WALK  = 3'd5;
  localparam logic [2:0] ST_DRAIN = 3'd6;

  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_NODES - 1);

  // Control state.
  logic [2:0]           state_q, state_d;
  logic [AW-1:0]        load_idx_q, load_idx_d;
  logic [AW-1:0]        current_q, current_d;
  logic [SYMBOLS_W-1:0] symbols_left_q, symbols_left_d;
  logic                 tree_error_q, tree_error_d;
  logic                 held_valid_q, held_valid_d;
  logic                 fin_present_q, fin_present_d;
  logic                 pend_q, pend_d;
  logic [3:0]           bits_q, bits_d;

  // Payload state.
  in_item_t    in_q, in_d;
  node_entry_t root_q, root_d;
  logic [AW-1:0] child_q, child_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  held_q, held_d;
  out_item_t   fin_q, fin_d;

  node_entry_t      n_ent;
  node_entry_t      e_ent;
  node_entry_t      p_ent;
  logic             leaf;
  logic             stall_walk;
  logic             go_on;
  logic             bitv;
  logic [IDX_W-1:0] child_idx;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d        = state_q;
    load_idx_d     = load_idx_q;
    current_d      = current_q;
    symbols_left_d = symbols_left_q;
    tree_error_d   = tree_error_q;
    held_valid_d   = held_valid_q;
    fin_present_d  = fin_present_q;
    pend_d         = pend_q;
    bits_d         = bits_q;
    in_d           = in_q;
    root_d         = root_q;
    child_d        = child_q;
    shift_d        = shift_q;
    held_d         = held_q;
    fin_d          = fin_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = load_idx_q;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    emit_o      = 1'b0;
    emit_item_o = '0;

    n_ent      = mem_rdata_i;
    e_ent      = mem_rdata_i;
    p_ent      = mem_rdata_i;
    leaf       = !mem_rdata_i.has_left;
    stall_walk = 1'b0;
    go_on      = 1'b0;
    bitv       = shift_q[7];
    child_idx  = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          state_d = (in_data_i.req_type == REQ_CODE) ? ST_BYTE : ST_REC;
        end
      end

      ST_REC: begin
        if (load_idx_q >= LAST_SLOT) begin
          // Table full (the last slot stays unused): the record is dropped.
          tree_error_d  = 1'b1;
          fin_d         = mk_result(8'd0, 1'b0, 1'b1, STATUS_BAD_TREE);
          fin_present_d = 1'b1;
          state_d       = ST_DRAIN;
        end else begin
          mem_we_o           = 1'b1;
          mem_waddr_o        = load_idx_q;
          mem_wdata_o.sym    = in_q.node_symbol;
          child_d            = load_idx_q;
          load_idx_d         = load_idx_q + 1'b1;
          fin_present_d      = 1'b1;
          state_d            = ST_DRAIN;
          fin_d = mk_result(8'd0, 1'b0, 1'b1, tree_error_q ? STATUS_BAD_TREE : STATUS_OK);
          if (load_idx_q == '0) begin
            symbols_left_d = symbol_total_i;
            current_d      = '0;
          end
          if (in_q.node_parent < 16'(NO_PARENT)) begin
            if (in_q.node_parent >= 16'(load_idx_q)) begin
              tree_error_d = 1'b1;
              fin_d        = mk_result(8'd0, 1'b0, 1'b1, STATUS_BAD_TREE);
            end else begin
              mem_re_o      = 1'b1;
              mem_raddr_o   = AW'(in_q.node_parent);
              fin_present_d = fin_present_q;
              state_d       = ST_RMW;
            end
          end
        end
      end

      ST_RMW: begin
        // Attach the new node as left child first, then as right child.
        if (!p_ent.has_left) begin
          p_ent.has_left = 1'b1;
          p_ent.left     = IDX_W'(child_q);
        end else begin
          p_ent.has_right = 1'b1;
          p_ent.right     = IDX_W'(child_q);
        end
        mem_we_o      = 1'b1;
        mem_waddr_o   = AW'(in_q.node_parent);
        mem_wdata_o   = p_ent;
        fin_d = mk_result(8'd0, 1'b0, 1'b1, tree_error_q ? STATUS_BAD_TREE : STATUS_OK);
        fin_present_d = 1'b1;
        state_d       = ST_DRAIN;
      end

      ST_BYTE: begin
        fin_present_d = 1'b1;
        state_d       = ST_DRAIN;
        if (load_idx_q == '0 || tree_error_q) begin
          fin_d = mk_result(8'd0, 1'b0, 1'b1, STATUS_BAD_TREE);
        end else if (symbols_left_q == '0) begin
          fin_d = mk_result(8'd0, 1'b0, 1'b1, STATUS_DONE);
        end else begin
          mem_re_o      = 1'b1;
          mem_raddr_o   = '0;
          fin_present_d = 1'b0;
          state_d       = ST_ROOT;
        end
      end

      ST_ROOT: begin
        if (!n_ent.has_left) begin
          fin_d         = mk_result(8'd0, 1'b0, 1'b1, STATUS_LEAF_ROOT);
          fin_present_d = 1'b1;
          state_d       = ST_DRAIN;
        end else begin
          root_d      = n_ent;
          mem_re_o    = 1'b1;
          mem_raddr_o = current_q;
          shift_d     = in_q.code_byte;
          bits_d      = 4'd8;
          pend_d      = 1'b0;
          state_d     = ST_WALK;
        end
      end

      ST_WALK: begin
        // A non-final leaf pushes out the symbol held before it, which needs the output slot.
        stall_walk = pend_q && leaf && (symbols_left_q != SYMBOLS_W'(1)) && held_valid_q &&
                     !slot_free_i;
        if (!stall_walk) begin
          go_on  = 1'b1;
          pend_d = 1'b0;
          if (pend_q) begin
            if (leaf) begin
              current_d = '0;
              e_ent     = root_q;
              if (symbols_left_q == SYMBOLS_W'(1)) begin
                symbols_left_d = '0;
                fin_d          = mk_result(n_ent.sym, 1'b1, 1'b1, STATUS_DONE);
                fin_present_d  = 1'b1;
                state_d        = ST_DRAIN;
                go_on          = 1'b0;
              end else begin
                symbols_left_d = symbols_left_q - 1'b1;
                if (held_valid_q) begin
                  emit_o      = 1'b1;
                  emit_item_o = mk_result(held_q, 1'b1, 1'b0, STATUS_OK);
                end
                held_d       = n_ent.sym;
                held_valid_d = 1'b1;
              end
            end else begin
              current_d = child_q;
            end
          end
          if (go_on) begin
            if (bits_q == '0) begin
              state_d = ST_DRAIN;
            end else if (bitv && !e_ent.has_right) begin
              tree_error_d  = 1'b1;
              fin_d         = mk_result(8'd0, 1'b0, 1'b1, STATUS_BAD_TREE);
              fin_present_d = 1'b1;
              state_d       = ST_DRAIN;
            end else begin
              child_idx   = bitv ? e_ent.right : e_ent.left;
              mem_re_o    = 1'b1;
              mem_raddr_o = AW'(child_idx);
              child_d     = AW'(child_idx);
              pend_d      = 1'b1;
              shift_d     = {shift_q[6:0], 1'b0};
              bits_d      = bits_q - 1'b1;
            end
          end
        end
      end

      ST_DRAIN: begin
        // The held symbol goes first; it is last only when no closing result follows.
        if (slot_free_i) begin
          emit_o = 1'b1;
          if (held_valid_q) begin
            emit_item_o  = mk_result(held_q, 1'b1, !fin_present_q, STATUS_OK);
            held_valid_d = 1'b0;
            if (!fin_present_q) begin
              state_d = ST_IDLE;
            end
          end else if (fin_present_q) begin
            emit_item_o   = fin_q;
            fin_present_d = 1'b0;
            state_d       = ST_IDLE;
          end else begin
            emit_item_o = mk_result(8'd0, 1'b0, 1'b1, STATUS_OK);
            state_d     = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      load_idx_q     <= '0;
      current_q      <= '0;
      symbols_left_q <= '0;
      tree_error_q   <= 1'b0;
      held_valid_q   <= 1'b0;
      fin_present_q  <= 1'b0;
      pend_q         <= 1'b0;
      bits_q         <= '0;
    end else begin
      state_q        <= state_d;
      load_idx_q     <= load_idx_d;
      current_q      <= current_d;
      symbols_left_q <= symbols_left_d;
      tree_error_q   <= tree_error_d;
      held_valid_q   <= held_valid_d;
      fin_present_q  <= fin_present_d;
      pend_q         <= pend_d;
      bits_q         <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    root_q  <= root_d;
    child_q <= child_d;
    shift_q <= shift_d;
    held_q  <= held_d;
    fin_q   <= fin_d;
  end

  a_emit_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> (state_q == ST_WALK || state_q == ST_DRAIN))
    else $error("result emitted outside walk or drain");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o |-> slot_free_i)
    else $error("result emitted into an occupied output register");

  a_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o))
    else $error("node table read and write hit the same entry");

  a_held_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> (state_q == ST_WALK || state_q == ST_DRAIN))
    else $error("held symbol outlived its code byte");

  a_walk_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (root_q.has_left && load_idx_q != '0))
    else $error("walk started on an empty tree or a leaf root");

endmodule
